// ----- sv/cau_pkg.sv -----
// shared operation and status codes for the complex arithmetic unit
package cau_pkg;

   // operation codes carried by req_type
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4,
      OP_MAG = 3'd5
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

endpackage

// ----- sv/cau_div_cell.sv -----
// one restoring divider cell: resolves a single quotient bit
module cau_div_cell #(
   parameter int RW  = 56,
   parameter int DW  = 32,
   parameter int QW  = 16,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [QW-1:0] quo_i,
   output logic [RW-1:0] rem_o,
   output logic [DW-1:0] den_o,
   output logic [QW-1:0] quo_o
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] trial;
   logic          take;

   // compare against the divisor weighted by this bit
   always_comb begin
      trial  = RW'(den_i) << BIT;
      take   = (rem_i >= trial);
      rem_in = take ? (rem_i - trial) : rem_i;
      quo_in = quo_i | (QW'(take) << BIT);
   end

   // hand partial remainder to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

// ----- sv/cau_sqrt_cell.sv -----
// one digit-by-digit square root cell: resolves a single root bit
module cau_sqrt_cell #(
   parameter int SW  = 32,
   parameter int QW  = 16,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [SW-1:0] rem_i,
   input  logic [QW-1:0] root_i,
   output logic [SW-1:0] rem_o,
   output logic [QW-1:0] root_o
);

   logic [SW-1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;
   logic [SW:0]   trial;
   logic          take;

   // trial term (2*root + 2^bit) * 2^bit
   always_comb begin
      trial   = ((SW+1)'(root_i) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
      take    = ({1'b0, rem_i} >= trial);
      rem_in  = take ? SW'({1'b0, rem_i} - trial) : rem_i;
      root_in = root_i | (QW'(take) << BIT);
   end

   // hand remainder and partial root to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ----- sv/complex_arithmetic_unit.sv -----
// complex arithmetic unit: add, sub, mul, div, compare, magnitude in signed fixed point
// the pipeline is four front stages, one cell per result bit, then an output register
// throughput is one transaction per cycle while not stalled; the divider and root chains take one bit per cell
// the whole pipeline advances together and stalls only while a result waits on rsp_ready
// reset clears the valid bits of every stage; payload registers are not reset
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_type,
   input  logic [DATA_WIDTH-1:0] req_a_re,
   input  logic [DATA_WIDTH-1:0] req_a_im,
   input  logic [DATA_WIDTH-1:0] req_b_re,
   input  logic [DATA_WIDTH-1:0] req_b_im,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_res_re,
   output logic [DATA_WIDTH-1:0] rsp_res_im,
   output logic                  rsp_is_equal,
   output logic [1:0]            rsp_status
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int RW = 3 * W + FRAC_BITS;
   localparam logic signed [PW:0] SMAX_X = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW:0] SMIN_X = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};

   typedef struct packed {
      op_type       op;
      logic         eq;
      logic         dz;
      logic [W-1:0] re;
      logic [W-1:0] im;
      logic         sat;
      logic         neg_re;
      logic         neg_im;
      logic         ovf_re;
      logic         ovf_im;
   } meta_type;

   // clamp to the signed result range, top bit flags saturation
   function automatic logic [W:0] clamp_fn(input logic signed [PW:0] x);
      logic         ovr;
      logic [W-1:0] v;
      ovr = (x > SMAX_X) || (x < SMIN_X);
      if (ovr) begin
         v = x[PW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         v = x[W-1:0];
      end
      return {ovr, v};
   endfunction

   // signed quotient from sign, overflow flag and magnitude
   function automatic logic [W:0] quo_fn(input logic neg, input logic ovf,
                                        input logic [W-1:0] q);
      logic signed [PW:0] t;
      logic [W:0]         r;
      t = (PW+1)'(q);
      if (neg) begin
         t = -t;
      end
      if (ovf) begin
         r = neg ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
         r = clamp_fn(t);
      end
      return r;
   endfunction

   logic en;
   logic out_valid_ff;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff;
   logic [W:0] vm_ff;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: products, squares, add or subtract, compare
   op_type               s1_op_ff;
   logic                 s1_eq_ff, s1_dz_ff;
   logic signed [W:0]    s1_as_re_ff, s1_as_im_ff;
   logic signed [PW-1:0] s1_p_rr_ff, s1_p_ii_ff, s1_p_ir_ff, s1_p_ri_ff;
   logic signed [PW-1:0] s1_bb_r_ff, s1_bb_i_ff, s1_aa_r_ff, s1_aa_i_ff;
   logic signed [W:0]    ext_ar, ext_ai, ext_br, ext_bi;

   assign ext_ar = {req_a_re[W-1], req_a_re};
   assign ext_ai = {req_a_im[W-1], req_a_im};
   assign ext_br = {req_b_re[W-1], req_b_re};
   assign ext_bi = {req_b_im[W-1], req_b_im};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff    <= op_type'(req_type);
         s1_eq_ff    <= (req_a_re == req_b_re) && (req_a_im == req_b_im);
         s1_dz_ff    <= (req_b_re == '0) && (req_b_im == '0);
         s1_as_re_ff <= (op_type'(req_type) == OP_SUB) ? ext_ar - ext_br : ext_ar + ext_br;
         s1_as_im_ff <= (op_type'(req_type) == OP_SUB) ? ext_ai - ext_bi : ext_ai + ext_bi;
         s1_p_rr_ff  <= $signed(req_a_re) * $signed(req_b_re);
         s1_p_ii_ff  <= $signed(req_a_im) * $signed(req_b_im);
         s1_p_ir_ff  <= $signed(req_a_im) * $signed(req_b_re);
         s1_p_ri_ff  <= $signed(req_a_re) * $signed(req_b_im);
         s1_bb_r_ff  <= $signed(req_b_re) * $signed(req_b_re);
         s1_bb_i_ff  <= $signed(req_b_im) * $signed(req_b_im);
         s1_aa_r_ff  <= $signed(req_a_re) * $signed(req_a_re);
         s1_aa_i_ff  <= $signed(req_a_im) * $signed(req_a_im);
      end
   end

   // stage 2: sums of products
   op_type             s2_op_ff;
   logic               s2_eq_ff, s2_dz_ff;
   logic signed [W:0]  s2_as_re_ff, s2_as_im_ff;
   logic signed [PW:0] s2_mul_re_ff, s2_mul_im_ff, s2_num_re_ff, s2_num_im_ff;
   logic [PW-1:0]      s2_den_ff, s2_sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff     <= s1_op_ff;
         s2_eq_ff     <= s1_eq_ff;
         s2_dz_ff     <= s1_dz_ff;
         s2_as_re_ff  <= s1_as_re_ff;
         s2_as_im_ff  <= s1_as_im_ff;
         s2_mul_re_ff <= (PW+1)'(s1_p_rr_ff) - (PW+1)'(s1_p_ii_ff);
         s2_mul_im_ff <= (PW+1)'(s1_p_ir_ff) + (PW+1)'(s1_p_ri_ff);
         s2_num_re_ff <= (PW+1)'(s1_p_rr_ff) + (PW+1)'(s1_p_ii_ff);
         s2_num_im_ff <= (PW+1)'(s1_p_ir_ff) - (PW+1)'(s1_p_ri_ff);
         s2_den_ff    <= s1_bb_r_ff + s1_bb_i_ff;
         s2_sq_ff     <= s1_aa_r_ff + s1_aa_i_ff;
      end
   end

   // stage 3: clamp simple results, take numerator magnitudes
   meta_type           s3_meta_ff, s3_meta_in;
   logic [PW-1:0]      s3_mag_re_ff, s3_mag_im_ff, s3_den_ff, s3_sq_ff;
   logic signed [PW:0] s3_pre_re, s3_pre_im, s3_abs_re, s3_abs_im;
   logic [W:0]         s3_cl_re, s3_cl_im;

   always_comb begin
      if (s2_op_ff == OP_MUL) begin
         s3_pre_re = s2_mul_re_ff >>> FRAC_BITS;
         s3_pre_im = s2_mul_im_ff >>> FRAC_BITS;
      end else begin
         s3_pre_re = {{(PW-W){s2_as_re_ff[W]}}, s2_as_re_ff};
         s3_pre_im = {{(PW-W){s2_as_im_ff[W]}}, s2_as_im_ff};
      end
      s3_cl_re  = clamp_fn(s3_pre_re);
      s3_cl_im  = clamp_fn(s3_pre_im);
      s3_abs_re = s2_num_re_ff[PW] ? -s2_num_re_ff : s2_num_re_ff;
      s3_abs_im = s2_num_im_ff[PW] ? -s2_num_im_ff : s2_num_im_ff;
      s3_meta_in        = '0;
      s3_meta_in.op     = s2_op_ff;
      s3_meta_in.eq     = s2_eq_ff;
      s3_meta_in.dz     = s2_dz_ff;
      s3_meta_in.re     = s3_cl_re[W-1:0];
      s3_meta_in.im     = s3_cl_im[W-1:0];
      s3_meta_in.sat    = s3_cl_re[W] || s3_cl_im[W];
      s3_meta_in.neg_re = s2_num_re_ff[PW];
      s3_meta_in.neg_im = s2_num_im_ff[PW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_meta_ff   <= s3_meta_in;
         s3_mag_re_ff <= s3_abs_re[PW-1:0];
         s3_mag_im_ff <= s3_abs_im[PW-1:0];
         s3_den_ff    <= s2_den_ff;
         s3_sq_ff     <= s2_sq_ff;
      end
   end

   // stage 4: scale numerators and check quotient overflow
   meta_type      meta_ff [0:W];
   meta_type      s4_meta_in;
   logic [RW-1:0] s4_num_re, s4_num_im, s4_den_top;
   logic [RW-1:0] dre_rem [0:W];
   logic [RW-1:0] dim_rem [0:W];
   logic [PW-1:0] dre_den [0:W];
   logic [PW-1:0] dim_den [0:W];
   logic [W-1:0]  dre_quo [0:W];
   logic [W-1:0]  dim_quo [0:W];
   logic [PW-1:0] sq_rem  [0:W];
   logic [W-1:0]  sq_root [0:W];
   logic [RW-1:0] s4_rem_re_ff, s4_rem_im_ff;
   logic [PW-1:0] s4_den_ff, s4_sq_ff;

   always_comb begin
      s4_num_re         = RW'(s3_mag_re_ff) << FRAC_BITS;
      s4_num_im         = RW'(s3_mag_im_ff) << FRAC_BITS;
      s4_den_top        = RW'(s3_den_ff) << W;
      s4_meta_in        = s3_meta_ff;
      s4_meta_in.ovf_re = (s4_num_re >= s4_den_top);
      s4_meta_in.ovf_im = (s4_num_im >= s4_den_top);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0]   <= s4_meta_in;
         s4_rem_re_ff <= s4_num_re;
         s4_rem_im_ff <= s4_num_im;
         s4_den_ff    <= s3_den_ff;
         s4_sq_ff     <= s3_sq_ff;
      end
   end

   assign dre_rem[0] = s4_rem_re_ff;
   assign dim_rem[0] = s4_rem_im_ff;
   assign dre_den[0] = s4_den_ff;
   assign dim_den[0] = s4_den_ff;
   assign dre_quo[0] = '0;
   assign dim_quo[0] = '0;
   assign sq_rem[0]  = s4_sq_ff;
   assign sq_root[0] = '0;

   // chain of cells, one result bit per cell, most significant first
   for (genvar i = 0; i < W; i++) begin : g_cell
      cau_div_cell #(.RW(RW), .DW(PW), .QW(W), .BIT(W - 1 - i)) u_div_re (
         .clock (clock),
         .en    (en),
         .rem_i (dre_rem[i]),
         .den_i (dre_den[i]),
         .quo_i (dre_quo[i]),
         .rem_o (dre_rem[i+1]),
         .den_o (dre_den[i+1]),
         .quo_o (dre_quo[i+1])
      );

      cau_div_cell #(.RW(RW), .DW(PW), .QW(W), .BIT(W - 1 - i)) u_div_im (
         .clock (clock),
         .en    (en),
         .rem_i (dim_rem[i]),
         .den_i (dim_den[i]),
         .quo_i (dim_quo[i]),
         .rem_o (dim_rem[i+1]),
         .den_o (dim_den[i+1]),
         .quo_o (dim_quo[i+1])
      );

      cau_sqrt_cell #(.SW(PW), .QW(W), .BIT(W - 1 - i)) u_sqrt (
         .clock  (clock),
         .en     (en),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff[i+1] <= meta_ff[i];
         end
      end
   end

   // valid bits follow the transaction down the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         vm_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vm_ff        <= {vm_ff[W-1:0], v3_ff};
         out_valid_ff <= vm_ff[W];
      end
   end

   // output select and final clamp
   meta_type     fin_meta;
   logic [W:0]   fin_qre, fin_qim;
   logic [W-1:0] res_re_in, res_im_in;
   logic         eq_in;
   status_type   status_in;
   logic [W-1:0] res_re_ff, res_im_ff;
   logic         eq_ff;
   status_type   status_ff;

   always_comb begin
      fin_meta  = meta_ff[W];
      fin_qre   = quo_fn(fin_meta.neg_re, fin_meta.ovf_re, dre_quo[W]);
      fin_qim   = quo_fn(fin_meta.neg_im, fin_meta.ovf_im, dim_quo[W]);
      eq_in     = fin_meta.eq;
      res_re_in = '0;
      res_im_in = '0;
      status_in = ST_OK;
      case (fin_meta.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            res_re_in = fin_meta.re;
            res_im_in = fin_meta.im;
            status_in = fin_meta.sat ? ST_SAT : ST_OK;
         end
         OP_DIV: begin
            if (fin_meta.dz) begin
               status_in = ST_DIV_ZERO;
            end else begin
               res_re_in = fin_qre[W-1:0];
               res_im_in = fin_qim[W-1:0];
               status_in = (fin_qre[W] || fin_qim[W]) ? ST_SAT : ST_OK;
            end
         end
         OP_MAG: begin
            if (sq_root[W][W-1]) begin
               res_re_in = {1'b0, {(W-1){1'b1}}};
               status_in = ST_SAT;
            end else begin
               res_re_in = sq_root[W];
            end
         end
         default: begin
            res_re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         eq_ff     <= eq_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_res_re   = res_re_ff;
   assign rsp_res_im   = res_im_ff;
   assign rsp_is_equal = eq_ff;
   assign rsp_status   = status_ff;

   // a stalled pipeline keeps its valid bits (checked for v1_ff, v3_ff and vm_ff)
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(vm_ff) && $stable(v3_ff) && $stable(v1_ff)))
      else $error("pipeline moved while stalled");

   // a new result comes only from the last cell
   a_out_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(vm_ff[W]))
      else $error("result without a transaction in the last cell");

   // division by zero gives zero parts
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIV_ZERO) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("nonzero result on division by zero");

endmodule
